>>> rtl/nbu_pkg.sv
// ----------------------------------------------------------------------------
// nbu_pkg
// Shared types, codes and elaboration-time helpers for the neuron
// backpropagation unit: operation and result codes, queue entry types, the
// saturation helper and the activation table generator.
// ----------------------------------------------------------------------------
package nbu_pkg;

    localparam int IDX_W       = 6;
    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int ACC_W       = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_FAN_IN         = 64;
    localparam int DEF_ACT_TABLE_SIZE = 256;

    localparam logic [11:0] LRATE_RESET    = 12'd614;
    localparam logic [11:0] MOMENTUM_RESET = 12'd2048;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_FORWARD  = 3'd1,
        OP_OUT_GRAD = 3'd2,
        OP_HIDDEN   = 3'd3,
        OP_UPDATE   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_WEIGHT   = 2'd0,
        KIND_OUTPUT   = 2'd1,
        KIND_GRADIENT = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACT_MODE = 2'd0,
        CFG_LRATE    = 2'd1,
        CFG_MOMENTUM = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FMUL,
        ST_FACC,
        ST_FACT,
        ST_FOUT,
        ST_HMUL,
        ST_HACC,
        ST_DMUL,
        ST_DRND,
        ST_GMUL,
        ST_GOUT,
        ST_HLO,
        ST_HHI,
        ST_HOUT,
        ST_UMUL1,
        ST_UMUL2,
        ST_UDEL,
        ST_UWR
    } state_t;

    typedef struct packed {
        op_t                       op;
        logic [IDX_W-1:0]          idx;
        logic                      inr;
        logic signed [DATA_W-1:0]  val;
        logic signed [DATA_W-1:0]  coef;
        logic                      last;
    } cmd_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  value;
        logic                      sat;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  v;
        logic                      f;
    } sat_t;

    // Clip a wide signed value to the 16-bit range and flag the clip.
    function automatic sat_t sat16(logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd32767) begin
            r.v = 16'sh7fff;
            r.f = 1'b1;
        end else if (v < -64'sd32768) begin
            r.v = 16'sh8000;
            r.f = 1'b1;
        end else begin
            r.v = v[15:0];
            r.f = 1'b0;
        end
        return r;
    endfunction

    // Restoring long division, used only while building constant tables.
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-t) in Q30 for t in Q12: fifth-order series on t/256, then eight
    // squarings. Intermediate values wrap at 64 bits.
    function automatic logic [63:0] exp_neg(logic [63:0] t);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] p;
        y    = t << 10;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (int k = 1; k <= 5; k++) begin
            p = (term * y) >> 30;
            case (k)
                1:       term = p;
                2:       term = p / 2;
                3:       term = p / 3;
                4:       term = p / 4;
                default: term = p / 5;
            endcase
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int i = 0; i < 8; i++) begin
            sum = (sum * sum + (64'd1 << 29)) >> 30;
        end
        return sum;
    endfunction

    // Activation table entry i of a table of the given size; mode 0 is the
    // sigmoid, mode 1 the hyperbolic tangent.
    function automatic logic signed [15:0] act_entry(int mode, int i, int size);
        logic [63:0]        n;
        logic signed [63:0] x;
        logic [63:0]        a;
        logic [63:0]        e;
        logic [63:0]        d;
        logic [63:0]        q;
        logic signed [63:0] r;
        n = 64'(i) * 64'd65536 + 64'd32768;
        x = $signed(udiv64(n, 64'(size))) - 64'sd32768;
        a = (x < 0) ? 64'(-x) : 64'(x);
        if (mode == 0) begin
            e = exp_neg(a);
            d = (64'd1 << 30) + e;
            q = udiv64((64'd1 << 42) + (d >> 1), d);
            r = (x < 0) ? 64'sd4096 - $signed(q) : $signed(q);
        end else begin
            e = exp_neg(a << 1);
            d = (64'd1 << 30) + e;
            q = udiv64((((64'd1 << 30) - e) << 12) + (d >> 1), d);
            r = (x < 0) ? -$signed(q) : $signed(q);
        end
        return r[15:0];
    endfunction

endpackage

>>> rtl/neuron_backprop_unit.sv
// ----------------------------------------------------------------------------
// neuron_backprop_unit
// One backpropagation neuron in Q4.12 with momentum weight updates.
// ----------------------------------------------------------------------------
// Items enter through push/full and leave through empty/pop; a two-entry
// command queue and a two-entry result queue decouple both sides.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
// the user must make them while the unit is idle, which the unit itself does
// not enforce. One shared sequencer executes a command at a time, taking it
// from the command queue while idle and stepping through the states of its
// operation, with extra steps for the last forward or hidden term. A result
// is pushed into the result queue in its last step and shows on the result
// ports once it reaches the head of that queue. Items that have no effect
// (unknown operation, load or update beyond the fan-in) are dropped on
// entry. When the receiver stalls, the result queue fills, the sequencer
// waits before taking a new command, and full rises once the command queue
// is also full.
// Reset clears the queues, accumulator, output, gradient, all deltas and
// the registers to their defaults; weights hold no value until loaded.
// ----------------------------------------------------------------------------
module neuron_backprop_unit #(
    parameter int FAN_IN         = nbu_pkg::DEF_FAN_IN,
    parameter int ACT_TABLE_SIZE = nbu_pkg::DEF_ACT_TABLE_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [nbu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nbu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          operation,
    input  logic [nbu_pkg::IDX_W-1:0]           index,
    input  logic signed [nbu_pkg::DATA_W-1:0]   value,
    input  logic signed [nbu_pkg::DATA_W-1:0]   coefficient,
    input  logic                                last,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          result_kind,
    output logic signed [nbu_pkg::DATA_W-1:0]   result_value,
    output logic                                saturated
);

    nbu_pkg::cmd_t    cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_full;
    logic             res_push;
    nbu_pkg::result_t res;
    nbu_pkg::result_t res_out;
    logic [$bits(nbu_pkg::result_t)-1:0] res_bits;

    nbu_front #(
        .FAN_IN (FAN_IN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .index       (index),
        .value       (value),
        .coefficient (coefficient),
        .last        (last),
        .cmd         (cmd),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop)
    );

    nbu_back #(
        .FAN_IN         (FAN_IN),
        .ACT_TABLE_SIZE (ACT_TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    nbu_fifo #(
        .WIDTH ($bits(nbu_pkg::result_t)),
        .DEPTH (nbu_pkg::QUEUE_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_out      = nbu_pkg::result_t'(res_bits);
    assign result_kind  = res_out.kind;
    assign result_value = res_out.value;
    assign saturated    = res_out.sat;

endmodule

>>> rtl/nbu_fifo.sv
// ----------------------------------------------------------------------------
// nbu_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module nbu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = nbu_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/nbu_front.sv
// ----------------------------------------------------------------------------
// nbu_front
// Input side: checks each item's operation and index, drops items that have
// no effect, and queues the rest as commands for the execution side.
// ----------------------------------------------------------------------------
module nbu_front #(
    parameter int FAN_IN = nbu_pkg::DEF_FAN_IN
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          operation,
    input  logic [nbu_pkg::IDX_W-1:0]           index,
    input  logic signed [nbu_pkg::DATA_W-1:0]   value,
    input  logic signed [nbu_pkg::DATA_W-1:0]   coefficient,
    input  logic                                last,
    output nbu_pkg::cmd_t                       cmd,
    output logic                                cmd_empty,
    input  logic                                cmd_pop
);

    nbu_pkg::cmd_t cmd_in;
    logic          known_op;
    logic          keep;
    logic [$bits(nbu_pkg::cmd_t)-1:0] rd_bits;

    always_comb
    begin
        known_op = operation inside {nbu_pkg::OP_LOAD, nbu_pkg::OP_FORWARD,
                                     nbu_pkg::OP_OUT_GRAD, nbu_pkg::OP_HIDDEN,
                                     nbu_pkg::OP_UPDATE};
        cmd_in.op   = nbu_pkg::op_t'(operation);
        cmd_in.idx  = index;
        cmd_in.inr  = (32'(index) < FAN_IN);
        cmd_in.val  = value;
        cmd_in.coef = coefficient;
        cmd_in.last = last;
        // Loads and updates to a connection that does not exist do nothing.
        keep = known_op && (cmd_in.inr || !((cmd_in.op == nbu_pkg::OP_LOAD) ||
                                            (cmd_in.op == nbu_pkg::OP_UPDATE)));
    end

    nbu_fifo #(
        .WIDTH ($bits(nbu_pkg::cmd_t)),
        .DEPTH (nbu_pkg::QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && keep),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (rd_bits),
        .empty   (cmd_empty)
    );

    assign cmd = nbu_pkg::cmd_t'(rd_bits);

endmodule

>>> rtl/nbu_back.sv
// ----------------------------------------------------------------------------
// nbu_back
// Execution side: a sequencer over one shared datapath holding the weight and
// delta stores, the accumulator, the neuron output and gradient, and the
// configuration registers.
// ----------------------------------------------------------------------------
module nbu_back #(
    parameter int FAN_IN         = nbu_pkg::DEF_FAN_IN,
    parameter int ACT_TABLE_SIZE = nbu_pkg::DEF_ACT_TABLE_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [nbu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nbu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  nbu_pkg::cmd_t                       cmd,
    input  logic                                cmd_empty,
    output logic                                cmd_pop,
    input  logic                                res_full,
    output logic                                res_push,
    output nbu_pkg::result_t                    res
);

    localparam int MAXD  = 1 << nbu_pkg::IDX_W;
    localparam int DEPTH = (FAN_IN < MAXD) ? FAN_IN : MAXD;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(ACT_TABLE_SIZE);

    nbu_pkg::state_t state_reg;
    nbu_pkg::state_t state_next;

    logic        mode_reg;
    logic [11:0] lrate_reg;
    logic [11:0] mom_reg;

    logic signed [15:0] wmem_reg [DEPTH];
    logic signed [15:0] dmem_reg [DEPTH];
    logic [DEPTH-1:0]   dvalid_reg;

    nbu_pkg::cmd_t      cmd_reg;
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] d_rd_reg;
    logic               dv_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] o_reg;
    logic signed [15:0] g_reg;
    logic [TW-1:0]      t_reg;
    logic signed [32:0] dp_reg;
    logic signed [21:0] d_reg;
    logic signed [38:0] gp_reg;
    logic signed [38:0] plo_reg;
    logic signed [62:0] hsum_reg;
    logic signed [28:0] t1_reg;
    logic signed [28:0] m_reg;
    logic signed [44:0] t2_reg;
    logic signed [15:0] nd_reg;
    logic               ndf_reg;

    logic               rd_en;
    logic               w_we;
    logic               d_we;
    logic               dv_clr;
    logic signed [15:0] w_wdata;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [nbu_pkg::IDX_W+AW-1:0] rd_ext;
    logic [nbu_pkg::IDX_W+AW-1:0] wr_ext;

    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic signed [40:0] acc_rnd;
    nbu_pkg::sat_t      s_fwd;
    logic [15:0]        u_fwd;
    logic [16+TW:0]     t_prod;
    logic signed [16:0] om;
    logic signed [33:0] dp_rnd;
    logic signed [21:0] d_raw;
    logic signed [16:0] diff;
    logic signed [39:0] gp_rnd;
    nbu_pkg::sat_t      s_grad;
    logic signed [45:0] phi;
    logic signed [63:0] h_rnd;
    nbu_pkg::sat_t      s_hid;
    logic signed [15:0] d_old;
    logic signed [45:0] step_rnd;
    logic signed [29:0] mom_rnd;
    logic signed [22:0] nd_sum;
    nbu_pkg::sat_t      s_nd;
    nbu_pkg::sat_t      s_w;

    logic signed [15:0] act_tbl [2][ACT_TABLE_SIZE];

    for (genvar m = 0; m < 2; m++)
    begin : g_mode
        for (genvar i = 0; i < ACT_TABLE_SIZE; i++)
        begin : g_entry
            assign act_tbl[m][i] = nbu_pkg::act_entry(m, i, ACT_TABLE_SIZE);
        end
    end

    assign rd_ext  = {{AW{1'b0}}, cmd.idx};
    assign wr_ext  = {{AW{1'b0}}, cmd_reg.idx};
    assign rd_addr = rd_ext[AW-1:0];
    assign wr_addr = wr_ext[AW-1:0];

    // Datapath arithmetic, one step per state.
    always_comb
    begin
        acc_sum = {acc_reg[39], acc_reg} + 41'(prod_reg);
        if (acc_sum[40] != acc_sum[39])
        begin
            acc_sat = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[39:0];
        end
        acc_rnd = {acc_reg[39], acc_reg} + 41'sd2048;
        s_fwd   = nbu_pkg::sat16(64'($signed(acc_rnd[40:12])));
        u_fwd   = {~s_fwd.v[15], s_fwd.v[14:0]};
        t_prod  = (17+TW)'(u_fwd) * (17+TW)'(ACT_TABLE_SIZE);

        om     = 17'sd4096 - 17'(o_reg);
        dp_rnd = 34'(dp_reg) + 34'sd2048;
        d_raw  = dp_rnd[33:12];

        diff   = 17'(cmd_reg.val) - 17'(o_reg);
        gp_rnd = 40'(gp_reg) + 40'sd2048;
        s_grad = nbu_pkg::sat16(64'($signed(gp_rnd[39:12])));

        phi    = $signed(acc_reg[39:16]) * d_reg;
        h_rnd  = 64'(hsum_reg) + 64'sd8388608;
        s_hid  = nbu_pkg::sat16(64'($signed(h_rnd[63:24])));

        d_old    = dv_rd_reg ? d_rd_reg : 16'sd0;
        step_rnd = 46'(t2_reg) + 46'sd8388608;
        mom_rnd  = 30'(m_reg) + 30'sd2048;
        nd_sum   = 23'($signed(step_rnd[45:24])) + 23'($signed(mom_rnd[29:12]));
        s_nd     = nbu_pkg::sat16(64'(nd_sum));
        s_w      = nbu_pkg::sat16(64'(17'(w_rd_reg) + 17'(nd_reg)));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nbu_pkg::ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    case (cmd.op)
                        nbu_pkg::OP_LOAD:     state_next = nbu_pkg::ST_LOAD;
                        nbu_pkg::OP_FORWARD:  state_next = nbu_pkg::ST_FMUL;
                        nbu_pkg::OP_OUT_GRAD: state_next = nbu_pkg::ST_DMUL;
                        nbu_pkg::OP_HIDDEN:   state_next = nbu_pkg::ST_HMUL;
                        nbu_pkg::OP_UPDATE:   state_next = nbu_pkg::ST_UMUL1;
                        default:              state_next = nbu_pkg::ST_IDLE;
                    endcase
                end
            end
            nbu_pkg::ST_LOAD:  state_next = nbu_pkg::ST_IDLE;
            nbu_pkg::ST_FMUL:  state_next = nbu_pkg::ST_FACC;
            nbu_pkg::ST_FACC:  state_next = cmd_reg.last ? nbu_pkg::ST_FACT : nbu_pkg::ST_IDLE;
            nbu_pkg::ST_FACT:  state_next = nbu_pkg::ST_FOUT;
            nbu_pkg::ST_FOUT:  state_next = nbu_pkg::ST_IDLE;
            nbu_pkg::ST_HMUL:  state_next = nbu_pkg::ST_HACC;
            nbu_pkg::ST_HACC:  state_next = cmd_reg.last ? nbu_pkg::ST_DMUL : nbu_pkg::ST_IDLE;
            nbu_pkg::ST_DMUL:  state_next = nbu_pkg::ST_DRND;
            nbu_pkg::ST_DRND:
            begin
                state_next = (cmd_reg.op == nbu_pkg::OP_HIDDEN) ? nbu_pkg::ST_HLO
                                                                : nbu_pkg::ST_GMUL;
            end
            nbu_pkg::ST_GMUL:  state_next = nbu_pkg::ST_GOUT;
            nbu_pkg::ST_GOUT:  state_next = nbu_pkg::ST_IDLE;
            nbu_pkg::ST_HLO:   state_next = nbu_pkg::ST_HHI;
            nbu_pkg::ST_HHI:   state_next = nbu_pkg::ST_HOUT;
            nbu_pkg::ST_HOUT:  state_next = nbu_pkg::ST_IDLE;
            nbu_pkg::ST_UMUL1: state_next = nbu_pkg::ST_UMUL2;
            nbu_pkg::ST_UMUL2: state_next = nbu_pkg::ST_UDEL;
            nbu_pkg::ST_UDEL:  state_next = nbu_pkg::ST_UWR;
            nbu_pkg::ST_UWR:   state_next = nbu_pkg::ST_IDLE;
            default:           state_next = nbu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        rd_en     = 1'b0;
        w_we      = 1'b0;
        d_we      = 1'b0;
        dv_clr    = 1'b0;
        w_wdata   = cmd_reg.val;
        res_push  = 1'b0;
        res.kind  = nbu_pkg::KIND_WEIGHT;
        res.value = cmd_reg.val;
        res.sat   = 1'b0;
        case (state_reg)
            nbu_pkg::ST_IDLE:
            begin
                cmd_pop = !cmd_empty && !res_full;
                rd_en   = cmd_pop;
            end
            nbu_pkg::ST_LOAD:
            begin
                w_we     = 1'b1;
                dv_clr   = 1'b1;
                res_push = 1'b1;
            end
            nbu_pkg::ST_FOUT:
            begin
                res_push  = 1'b1;
                res.kind  = nbu_pkg::KIND_OUTPUT;
                res.value = act_tbl[mode_reg][t_reg];
            end
            nbu_pkg::ST_GOUT:
            begin
                res_push  = 1'b1;
                res.kind  = nbu_pkg::KIND_GRADIENT;
                res.value = s_grad.v;
                res.sat   = s_grad.f;
            end
            nbu_pkg::ST_HOUT:
            begin
                res_push  = 1'b1;
                res.kind  = nbu_pkg::KIND_GRADIENT;
                res.value = s_hid.v;
                res.sat   = s_hid.f;
            end
            nbu_pkg::ST_UDEL:
            begin
                d_we = 1'b1;
            end
            nbu_pkg::ST_UWR:
            begin
                w_we      = 1'b1;
                w_wdata   = s_w.v;
                res_push  = 1'b1;
                res.value = s_w.v;
                res.sat   = s_w.f || ndf_reg;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nbu_pkg::ST_IDLE;
            mode_reg   <= 1'b0;
            lrate_reg  <= nbu_pkg::LRATE_RESET;
            mom_reg    <= nbu_pkg::MOMENTUM_RESET;
            acc_reg    <= '0;
            o_reg      <= '0;
            g_reg      <= '0;
            dvalid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    nbu_pkg::CFG_ACT_MODE: mode_reg  <= cfg_data[0];
                    nbu_pkg::CFG_LRATE:    lrate_reg <= cfg_data;
                    nbu_pkg::CFG_MOMENTUM: mom_reg   <= cfg_data;
                    default:               mode_reg  <= mode_reg;
                endcase
            end
            if (dv_clr)
            begin
                dvalid_reg[wr_addr] <= 1'b0;
            end
            else if (d_we)
            begin
                dvalid_reg[wr_addr] <= 1'b1;
            end
            case (state_reg)
                nbu_pkg::ST_FACC,
                nbu_pkg::ST_HACC: acc_reg <= acc_sat;
                nbu_pkg::ST_FOUT:
                begin
                    o_reg   <= act_tbl[mode_reg][t_reg];
                    acc_reg <= '0;
                end
                nbu_pkg::ST_GOUT: g_reg <= s_grad.v;
                nbu_pkg::ST_HOUT:
                begin
                    g_reg   <= s_hid.v;
                    acc_reg <= '0;
                end
                default:          g_reg <= g_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (rd_en)
        begin
            w_rd_reg  <= wmem_reg[rd_addr];
            d_rd_reg  <= dmem_reg[rd_addr];
            dv_rd_reg <= dvalid_reg[rd_addr];
        end
        if (w_we)
        begin
            wmem_reg[wr_addr] <= w_wdata;
        end
        if (d_we)
        begin
            dmem_reg[wr_addr] <= s_nd.v;
        end
        case (state_reg)
            nbu_pkg::ST_FMUL:  prod_reg <= cmd_reg.inr ? 32'(cmd_reg.val * w_rd_reg) : '0;
            nbu_pkg::ST_HMUL:  prod_reg <= 32'(cmd_reg.val * cmd_reg.coef);
            nbu_pkg::ST_FACT:  t_reg    <= t_prod[16+TW-1:16];
            nbu_pkg::ST_DMUL:  dp_reg   <= mode_reg ? 33'(o_reg * o_reg) : 33'(o_reg * om);
            nbu_pkg::ST_DRND:  d_reg    <= mode_reg ? 22'sd4096 - d_raw : d_raw;
            nbu_pkg::ST_GMUL:  gp_reg   <= 39'(diff * d_reg);
            nbu_pkg::ST_HLO:   plo_reg  <= 39'($signed({1'b0, acc_reg[15:0]}) * d_reg);
            nbu_pkg::ST_HHI:   hsum_reg <= $signed({phi[45], phi, 16'h0000}) + 63'(plo_reg);
            nbu_pkg::ST_UMUL1:
            begin
                t1_reg <= 29'($signed({1'b0, lrate_reg}) * cmd_reg.val);
                m_reg  <= 29'($signed({1'b0, mom_reg}) * d_old);
            end
            nbu_pkg::ST_UMUL2: t2_reg   <= 45'(t1_reg * g_reg);
            nbu_pkg::ST_UDEL:
            begin
                nd_reg  <= s_nd.v;
                ndf_reg <= s_nd.f;
            end
            default:           t_reg    <= t_reg;
        endcase
    end

    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !res_full)
        else $error("command taken without room for its result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nbu_pkg::ST_IDLE) |-> !cmd_pop)
        else $error("command taken while another is in progress");

    a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (state_reg == nbu_pkg::ST_LOAD || state_reg == nbu_pkg::ST_FOUT ||
                      state_reg == nbu_pkg::ST_GOUT || state_reg == nbu_pkg::ST_HOUT ||
                      state_reg == nbu_pkg::ST_UWR))
        else $error("result pushed outside a finishing step");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nbu_pkg::ST_FOUT || state_reg == nbu_pkg::ST_HOUT) |=> acc_reg == '0)
        else $error("accumulator not cleared after a final term");

endmodule

>>> tb/sv/neuron_backprop_unit_tb.sv
// ----------------------------------------------------------------------------
// neuron_backprop_unit_tb
// Self-checking bench for the backpropagation neuron. A directed table of
// items is followed by random training sequences under several register
// settings and idling phases. Every result is checked against a behavioural
// model of the neuron held in the bench or, for typed rows, against the table.
// ----------------------------------------------------------------------------
module neuron_backprop_unit_tb;

    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint Q30     = 64'sd1 << 30;

    typedef struct {
        logic [2:0]      op;
        logic [5:0]      idx;
        logic [15:0]     val;
        logic [15:0]     coef;
        logic            lst;
        bit              typed;
        nbu_pkg::kind_t  kind;
        logic [15:0]     rval;
        logic            sat;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [11:0]       cfg_data;
    logic              push;
    logic              full;
    logic [2:0]        operation;
    logic [5:0]        index;
    logic signed [15:0] value;
    logic signed [15:0] coefficient;
    logic              last;
    logic              empty;
    logic              pop = 1'b0;
    logic [1:0]        result_kind;
    logic signed [15:0] result_value;
    logic              saturated;

    neuron_backprop_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .operation(operation),
        .index(index), .value(value), .coefficient(coefficient), .last(last),
        .empty(empty), .pop(pop), .result_kind(result_kind),
        .result_value(result_value), .saturated(saturated)
    );

    // Neuron model state.
    logic signed [15:0] act_lut [2][256];
    logic signed [15:0] weights [64];
    logic signed [15:0] deltas [64];
    bit                 loaded [64];
    longint             run_sum;
    logic signed [15:0] neuron_out;
    logic signed [15:0] neuron_grad;
    logic               mode_r;
    longint             lrate_r;
    longint             mom_r;

    nbu_pkg::result_t pending_results [$];
    int      errors = 0;
    int      items_sent;
    int      results_seen = 0;
    int      send_idle_pct;
    int      recv_stall_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned exp_q30(longint unsigned t);
        longint unsigned y, term, acc;
        y    = t << 10;
        term = Q30;
        acc  = Q30;
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * y) >> 30) / k;
            if (k % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        for (int i = 0; i < 8; i++) acc = (acc * acc + (Q30 >> 1)) >> 30;
        return acc;
    endfunction

    function automatic void build_luts();
        longint x;
        longint unsigned a, e, d, s, th;
        for (int i = 0; i < 256; i++)
        begin
            x = (longint'(i) * 65536 + 32768) / 256 - 32768;
            a = (x < 0) ? -x : x;
            e = exp_q30(a);
            d = Q30 + e;
            s = ((64'd1 << 42) + d / 2) / d;
            act_lut[0][i] = (x < 0) ? 16'(4096 - s) : 16'(s);
            e = exp_q30(2 * a);
            d = Q30 + e;
            th = (((Q30 - e) << 12) + d / 2) / d;
            act_lut[1][i] = (x < 0) ? 16'(-th) : 16'(th);
        end
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi, inout bit f);
        if (v > hi)
        begin
            f = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            f = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint slope();
        longint o;
        o = neuron_out;
        if (mode_r) return 4096 - rnd_shift(o * o, 12);
        return rnd_shift(o * (4096 - o), 12);
    endfunction

    // Advance the neuron model by one accepted item; returns 1 with a result.
    function automatic bit neuron_step(logic [2:0] op, logic [5:0] idx,
                                       logic signed [15:0] val,
                                       logic signed [15:0] coef, logic lst,
                                       output nbu_pkg::result_t res);
        bit     f;
        longint r, stp, mv, nd;
        f = 1'b0;
        res = '0;
        case (op)
            nbu_pkg::OP_LOAD:
            begin
                weights[idx] = val;
                deltas[idx]  = '0;
                loaded[idx]  = 1'b1;
                res = '{nbu_pkg::KIND_WEIGHT, val, 1'b0};
                return 1'b1;
            end
            nbu_pkg::OP_FORWARD:
            begin
                run_sum = clip(run_sum + longint'(val) * weights[idx], SUM_MIN, SUM_MAX, f);
                if (!lst) return 1'b0;
                r = clip(rnd_shift(run_sum, 12), -32768, 32767, f);
                run_sum = 0;
                neuron_out = act_lut[mode_r][(r + 32768) >> 8];
                res = '{nbu_pkg::KIND_OUTPUT, neuron_out, 1'b0};
                return 1'b1;
            end
            nbu_pkg::OP_OUT_GRAD:
            begin
                r = clip(rnd_shift((longint'(val) - neuron_out) * slope(), 12),
                         -32768, 32767, f);
                neuron_grad = 16'(r);
                res = '{nbu_pkg::KIND_GRADIENT, 16'(r), f};
                return 1'b1;
            end
            nbu_pkg::OP_HIDDEN:
            begin
                run_sum = clip(run_sum + longint'(val) * coef, SUM_MIN, SUM_MAX, f);
                if (!lst) return 1'b0;
                f = 1'b0;
                r = clip(rnd_shift(run_sum * slope(), 24), -32768, 32767, f);
                run_sum = 0;
                neuron_grad = 16'(r);
                res = '{nbu_pkg::KIND_GRADIENT, 16'(r), f};
                return 1'b1;
            end
            nbu_pkg::OP_UPDATE:
            begin
                stp = rnd_shift(lrate_r * val * neuron_grad, 24);
                mv  = rnd_shift(mom_r * deltas[idx], 12);
                nd  = clip(stp + mv, -32768, 32767, f);
                deltas[idx] = 16'(nd);
                r = clip(longint'(weights[idx]) + nd, -32768, 32767, f);
                weights[idx] = 16'(r);
                res = '{nbu_pkg::KIND_WEIGHT, 16'(r), f};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Present one item and hold it until the unit takes it.
    task automatic send_item(logic [2:0] op, logic [5:0] idx, logic [15:0] val,
                             logic [15:0] coef, logic lst, bit typed = 0,
                             nbu_pkg::result_t typed_res = '0);
        nbu_pkg::result_t res;
        int      gap;
        operation   <= op;
        index       <= idx;
        value       <= val;
        coefficient <= coef;
        last        <= lst;
        push        <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        if (neuron_step(op, idx, val, coef, lst, res))
            pending_results.insert(pending_results.size(), typed ? typed_res : res);
        if (op <= nbu_pkg::OP_UPDATE) items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_and_write(nbu_pkg::cfg_reg_t reg_idx, logic [11:0] data);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (reg_idx)
            nbu_pkg::CFG_ACT_MODE: mode_r  = data[0];
            nbu_pkg::CFG_LRATE:    lrate_r = longint'(data);
            default:               mom_r   = longint'(data);
        endcase
    endtask

    function automatic logic [15:0] rand_q();
        int r;
        r = $urandom_range(99);
        if (r < 10) return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
        if (r < 55) return 16'($signed($urandom_range(8192)) - 4096);
        return 16'($urandom);
    endfunction

    function automatic logic [5:0] loaded_idx();
        logic [5:0] i;
        do i = 6'($urandom_range(63)); while (!loaded[i]);
        return i;
    endfunction

    task automatic random_phase(int count);
        int target;
        int len;
        int r;
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                    send_item(nbu_pkg::OP_FORWARD, loaded_idx(), rand_q(), 16'($urandom),
                              k == len - 1);
            end
            else if (r < 50)
            begin
                send_item(nbu_pkg::OP_OUT_GRAD, 6'($urandom), rand_q(), 16'($urandom),
                          1'($urandom));
            end
            else if (r < 70)
            begin
                len = $urandom_range(5, 1);
                for (int k = 0; k < len; k++)
                    send_item(nbu_pkg::OP_HIDDEN, 6'($urandom), rand_q(), rand_q(),
                              k == len - 1);
            end
            else if (r < 90)
            begin
                send_item(nbu_pkg::OP_UPDATE, loaded_idx(), rand_q(), 16'($urandom),
                          1'($urandom));
            end
            else if (r < 95)
            begin
                send_item(nbu_pkg::OP_LOAD, 6'($urandom), rand_q(), 16'($urandom),
                          1'($urandom));
            end
            else
            begin
                // Unknown operations with random fields and a random last bit, as noise.
                send_item(3'($urandom_range(7, 5)), 6'($urandom), 16'($urandom),
                          16'($urandom), 1'($urandom));
            end
        end
    endtask

    // Result side: compare each item taken with the oldest expectation.
    always @(posedge clk)
    begin
        nbu_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind %0d value %0d", result_kind, result_value);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind expected %0d actual %0d", want.kind, result_kind);
                    errors++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value expected %0d actual %0d", want.value,
                           result_value);
                    errors++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated expected %0d actual %0d", want.sat, saturated);
                    errors++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        row_t table_rows [$];
        row_t rw;
        int   waited;
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        push = 1'b0; operation = '0; index = '0; value = '0;
        coefficient = '0; last = 1'b0;
        items_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        build_luts();
        for (int i = 0; i < 64; i++)
        begin
            weights[i] = '0; deltas[i] = '0; loaded[i] = 1'b0;
        end
        run_sum = 0; neuron_out = '0; neuron_grad = '0;
        mode_r = 1'b0;
        lrate_r = longint'(nbu_pkg::LRATE_RESET);
        mom_r = longint'(nbu_pkg::MOMENTUM_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items; typed expectations only where they are obvious.
        table_rows = '{
            '{nbu_pkg::OP_OUT_GRAD, 0, 16'h0000, 0, 0, 1, nbu_pkg::KIND_GRADIENT, 16'h0000, 0},
            '{nbu_pkg::OP_LOAD, 0, 16'h7fff, 0, 0, 1, nbu_pkg::KIND_WEIGHT, 16'h7fff, 0},
            '{nbu_pkg::OP_LOAD, 63, 16'h8000, 16'hffff, 1, 1, nbu_pkg::KIND_WEIGHT, 16'h8000, 0},
            '{nbu_pkg::OP_LOAD, 5, 16'h0000, 0, 0, 1, nbu_pkg::KIND_WEIGHT, 16'h0000, 0},
            '{3'd5, 1, 16'h1234, 0, 1, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{3'd6, 2, 16'hffff, 16'hffff, 1, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{3'd7, 63, 16'h8000, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_FORWARD, 0, 16'h7fff, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_FORWARD, 0, 16'h7fff, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_FORWARD, 63, 16'h8000, 0, 1, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_FORWARD, 63, 16'h7fff, 0, 1, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_OUT_GRAD, 0, 16'h7fff, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_OUT_GRAD, 0, 16'h8000, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_HIDDEN, 0, 16'h7fff, 16'h7fff, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_HIDDEN, 0, 16'h8000, 16'h8000, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_HIDDEN, 0, 16'h8000, 16'h7fff, 1, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_FORWARD, 5, 16'h1000, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_HIDDEN, 0, 16'h7fff, 16'h7fff, 1, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_UPDATE, 0, 16'h7fff, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_UPDATE, 63, 16'h8000, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_UPDATE, 5, 16'h7fff, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0},
            '{nbu_pkg::OP_UPDATE, 5, 16'h7fff, 0, 0, 0, nbu_pkg::KIND_WEIGHT, 0, 0}
        };
        foreach (table_rows[i])
        begin
            rw = table_rows[i];
            send_item(rw.op, rw.idx, rw.val, rw.coef, rw.lst, rw.typed,
                      '{rw.kind, rw.rval, rw.sat});
        end

        // Load every weight so that random sequences may read any of them.
        for (int i = 0; i < 64; i++)
            send_item(nbu_pkg::OP_LOAD, 6'(i), rand_q(), 16'($urandom), 1'($urandom));

        random_phase(420);
        drain_and_write(nbu_pkg::CFG_ACT_MODE, 12'd1);
        drain_and_write(nbu_pkg::CFG_LRATE, 12'd4095);
        drain_and_write(nbu_pkg::CFG_MOMENTUM, 12'd4095);
        send_idle_pct = 63;
        random_phase(420);
        drain_and_write(nbu_pkg::CFG_ACT_MODE, 12'd0);
        drain_and_write(nbu_pkg::CFG_LRATE, 12'd0);
        drain_and_write(nbu_pkg::CFG_MOMENTUM, 12'd0);
        send_idle_pct = 0; recv_stall_pct = 63;
        random_phase(420);
        drain_and_write(nbu_pkg::CFG_ACT_MODE, 12'd1);
        drain_and_write(nbu_pkg::CFG_LRATE, 12'($urandom));
        drain_and_write(nbu_pkg::CFG_MOMENTUM, 12'($urandom));
        send_idle_pct = 10; recv_stall_pct = 10;
        random_phase(500);
        push <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        $display("Sent %0d items, checked %0d results over four register settings",
                 items_sent, results_seen);
        $display("and four idling phases with %0d mismatches.", errors);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
